// ===== rtl/drt_pkg.sv =====
// Shared types and constants for the dirty rectangle tracker.
package drt_pkg;

  localparam int MAX_ENTRIES = 512;
  localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  localparam int IN_DATA_W = 80;
  localparam int IN_USER_W = 2;
  localparam int OUT_DATA_W = 80;
  localparam int IDX_W = 9;
  localparam int ECNT_W = 10;

  typedef enum logic [1:0] {
    FN_ADD   = 2'd0,
    FN_CLEAR = 2'd1,
    FN_READ  = 2'd2,
    FN_NONE  = 2'd3
  } fn_t;

  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_COVERED = 3'd1,
    ST_FULL    = 3'd2,
    ST_CLEARED = 3'd3,
    ST_READ    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RDWAIT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [15:0]        h;
    logic [15:0]        w;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } rect_t;

endpackage

// ===== rtl/drt_contain.sv =====
// Containment test of a new rectangle against one stored rectangle.
module drt_contain
  import drt_pkg::*;
(
  input  rect_t stored,
  input  rect_t probe,
  output logic  hit
);

  logic signed [17:0] s_x;
  logic signed [17:0] s_y;
  logic signed [17:0] p_x;
  logic signed [17:0] p_y;
  logic signed [17:0] s_right;
  logic signed [17:0] s_bottom;
  logic signed [17:0] p_right;
  logic signed [17:0] p_bottom;

  always_comb begin
    s_x = 18'(stored.x);
    s_y = 18'(stored.y);
    p_x = 18'(probe.x);
    p_y = 18'(probe.y);
    s_right  = s_x + $signed({2'b00, stored.w});
    s_bottom = s_y + $signed({2'b00, stored.h});
    p_right  = p_x + $signed({2'b00, probe.w});
    p_bottom = p_y + $signed({2'b00, probe.h});
    hit = (s_x <= p_x) && (s_y <= p_y) && (s_right >= p_right) && (s_bottom >= p_bottom);
  end

endmodule

// ===== rtl/dirty_rectangle_tracker_core.sv =====
// Top level of the dirty rectangle tracker: sequencer, rectangle memory and result register.
//
//   Channel  Direction  Fields (lowest bit first)
//   s_*      in         tuser: func; tdata: pos_x, pos_y, rect_w, rect_h, read_index
//   m_*      out        tdata: status, entry_count, out_x, out_y, out_w, out_h
//
// An add compares the new rectangle with the stored entries in turn, stopping at the
// first that contains it; the memory read port delivers one entry per cycle to the compare.
// A clear goes straight to S_FINISH and a read waits in S_RDWAIT. One request is in work at a time.
// Reset empties the list at once; the memory itself is not cleared.
// A stalled result is held in the output register and blocks the next request's finish.
module dirty_rectangle_tracker_core
  import drt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_USER_W-1:0]  s_tuser,   // func
  input  logic [IN_DATA_W-1:0]  s_tdata,   // pos_x, pos_y, rect_w, rect_h, read_index
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // status, entry_count, out_x, out_y, out_w, out_h
);

  state_t state;
  state_t state_next;

  fn_t               func;
  rect_t             probe;
  logic              idx_ok;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  issue_ptr;
  logic              last_q;
  logic              covered;
  rect_t             res_rect;

  rect_t             rect_mem [MAX_ENTRIES];
  rect_t             rdata;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;

  fn_t               in_func;
  rect_t             in_rect;
  logic [IDX_W-1:0]  in_idx;
  logic              hit;
  logic              out_free;
  logic              load_out;
  logic              full;
  status_t           res_status;

  assign in_func  = fn_t'(s_tuser);
  assign in_rect  = rect_t'(s_tdata[63:0]);
  assign in_idx   = s_tdata[72:64];
  assign out_free = !m_tvalid || m_tready;
  assign full     = count >= CNT_W'(MAX_ENTRIES);

  drt_contain u_contain (
    .stored(rdata),
    .probe (probe),
    .hit   (hit)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          unique case (in_func)
            FN_ADD:   state_next = (count == '0) ? S_FINISH : S_SCAN;
            FN_CLEAR: state_next = S_FINISH;
            FN_READ:  state_next = S_RDWAIT;
            FN_NONE:  state_next = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (hit || last_q) begin
          state_next = S_FINISH;
        end
      end
      S_RDWAIT: state_next = S_FINISH;
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = ADDR_W'(issue_ptr);
    load_out   = 1'b0;
    wr_en      = 1'b0;
    res_status = ST_READ;
    count_next = count;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid && in_func == FN_ADD) begin
          rd_en   = 1'b1;
          rd_addr = '0;
        end else if (s_tvalid && in_func == FN_READ) begin
          rd_en   = 1'b1;
          rd_addr = ADDR_W'(in_idx);
        end
      end
      S_SCAN: begin
        rd_en = !hit && !last_q;
      end
      S_RDWAIT: begin
      end
      S_FINISH: begin
        load_out = out_free;
        unique case (func)
          FN_ADD: begin
            if (covered) begin
              res_status = ST_COVERED;
            end else if (full) begin
              res_status = ST_FULL;
            end else begin
              res_status = ST_ADDED;
              wr_en      = out_free;
              count_next = count + 1'b1;
            end
          end
          FN_CLEAR: begin
            res_status = ST_CLEARED;
            count_next = '0;
          end
          FN_READ:  res_status = ST_READ;
          FN_NONE:  res_status = ST_READ;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= rect_mem[rd_addr];
    end
    if (wr_en) begin
      rect_mem[ADDR_W'(count)] <= probe;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid) begin
      func      <= in_func;
      probe     <= in_rect;
      idx_ok    <= int'(in_idx) < MAX_ENTRIES;
      covered   <= 1'b0;
      res_rect  <= '0;
      issue_ptr <= CNT_W'(1);
      last_q    <= count == CNT_W'(1);
    end else if (state == S_SCAN) begin
      if (hit) begin
        covered <= 1'b1;
      end
      if (rd_en) begin
        issue_ptr <= issue_ptr + 1'b1;
        last_q    <= issue_ptr == count - 1'b1;
      end
    end else if (state == S_RDWAIT) begin
      res_rect <= idx_ok ? rdata : '0;
    end
    if (load_out) begin
      m_tdata <= {3'b000, res_rect, ECNT_W'(count_next), res_status};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ENTRIES))
    else $error("stored entry count beyond list depth");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    (load_out && res_status == ST_ADDED) |=> count == $past(count) + 1'b1)
    else $error("appended rectangle did not raise the count");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (load_out && res_status == ST_CLEARED) |=> count == '0)
    else $error("clear left entries in the list");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (issue_ptr <= count && issue_ptr != '0))
    else $error("scan pointer outside the stored entries");

endmodule

// ===== dv/tb_dirty_rectangle_tracker_core.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the dirty rectangle tracker core with a shadow rectangle list.
module tb_dirty_rectangle_tracker_core;
  import drt_pkg::*;

  localparam int NUM_ITEMS = 1170;
  localparam int CALM_ITEMS = 150;
  localparam int HOLD_CYCLES = 3000;
  localparam int MAX_REPORTS = 10;
  localparam int NUM_ROWS = 23;

  typedef struct packed {
    fn_t              func;
    rect_t            r;
    logic [IDX_W-1:0] idx;
  } req_t;

  typedef struct packed {
    status_t           st;
    logic [ECNT_W-1:0] cnt;
    rect_t             r;
  } reply_t;

  typedef struct {
    fn_t     func;
    int      x, y, w, h, idx;
    bit      typed;
    status_t st;
    int      cnt;
    int      ox, oy, ow, oh;
  } row_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_USER_W-1:0]  s_tuser;   // func
  logic [IN_DATA_W-1:0]  s_tdata;   // pos_x, pos_y, rect_w, rect_h, read_index
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // status, entry_count, out_x, out_y, out_w, out_h

  rect_t  shadow_rects [MAX_ENTRIES];
  int     shadow_count;
  int     rects_written;
  reply_t tracker_replies_q [$];
  int     sent;
  int     replies_seen;
  int     bad_count;
  bit     calm;
  bit     hold_req;
  bit     hold_done;

  row_t dir_rows [NUM_ROWS] = '{
    '{FN_ADD,   -32768, -32768, 65535, 65535,   0, 1, ST_ADDED,   1, 0, 0, 0, 0},
    '{FN_ADD,        0,      0,     1,     1,   0, 1, ST_COVERED, 1, 0, 0, 0, 0},
    '{FN_ADD,    32767,  32767, 65535, 65535,   0, 1, ST_ADDED,   2, 0, 0, 0, 0},
    '{FN_ADD,    32767,  32767,     0,     0,   0, 1, ST_COVERED, 2, 0, 0, 0, 0},
    '{FN_READ,       0,      0,     0,     0,   0, 1, ST_READ,    2, -32768, -32768, 65535, 65535},
    '{FN_READ,       0,      0,     0,     0,   1, 1, ST_READ,    2, 32767, 32767, 65535, 65535},
    '{FN_NONE,    1234,  -4321,   777,   888, 511, 0, ST_ADDED,   0, 0, 0, 0, 0},
    '{FN_ADD,      100,   -200,   300,   400,   0, 0, ST_ADDED,   0, 0, 0, 0, 0},
    '{FN_CLEAR,     -1,     -1, 65535, 65535, 511, 1, ST_CLEARED, 0, 0, 0, 0, 0},
    '{FN_READ,       0,      0,     0,     0,   1, 1, ST_READ,    0, 32767, 32767, 65535, 65535},
    '{FN_ADD,        0,      0,     0,     0,   0, 1, ST_ADDED,   1, 0, 0, 0, 0},
    '{FN_ADD,        0,      0,     0,     0,   0, 1, ST_COVERED, 1, 0, 0, 0, 0},
    '{FN_ADD,        5,      5,     0,     0,   0, 0, ST_ADDED,   0, 0, 0, 0, 0},
    '{FN_ADD,       -1,     -1,     2,     2,   0, 0, ST_ADDED,   0, 0, 0, 0, 0},
    '{FN_ADD,        0,      0,     1,     1,   0, 0, ST_ADDED,   0, 0, 0, 0, 0},
    '{FN_ADD,       -1,     -1,     2,     3,   0, 0, ST_ADDED,   0, 0, 0, 0, 0},
    '{FN_READ,       0,      0,     0,     0,   3, 0, ST_ADDED,   0, 0, 0, 0, 0},
    '{FN_ADD,   -32768,  32767,     0, 65535,   0, 0, ST_ADDED,   0, 0, 0, 0, 0},
    '{FN_READ,       0,      0,     0,     0,   4, 0, ST_ADDED,   0, 0, 0, 0, 0},
    '{FN_CLEAR,      0,      0,     0,     0,   0, 1, ST_CLEARED, 0, 0, 0, 0, 0},
    '{FN_CLEAR,      0,      0,     0,     0,   0, 1, ST_CLEARED, 0, 0, 0, 0, 0},
    '{FN_READ,       0,      0,     0,     0,   0, 0, ST_ADDED,   0, 0, 0, 0, 0},
    '{FN_READ,       0,      0,     0,     0,   2, 0, ST_ADDED,   0, 0, 0, 0, 0}
  };

  dirty_rectangle_tracker_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic rect_t mk_rect(input int x, input int y, input int w, input int h);
    rect_t r;
    r.x = x[15:0];
    r.y = y[15:0];
    r.w = w[15:0];
    r.h = h[15:0];
    return r;
  endfunction

  function automatic bit apply_request(input req_t q, output reply_t a);
    int x, y, w, h, sx, sy, sw, sh;
    bit hit;
    a = '0;
    hit = 1'b0;
    x = $signed(q.r.x);
    y = $signed(q.r.y);
    w = q.r.w;
    h = q.r.h;
    case (q.func)
      FN_ADD: begin
        for (int k = 0; k < shadow_count && !hit; k++) begin
          sx = $signed(shadow_rects[k].x);
          sy = $signed(shadow_rects[k].y);
          sw = shadow_rects[k].w;
          sh = shadow_rects[k].h;
          hit = (sx <= x) && (sy <= y) && (sx + sw >= x + w) && (sy + sh >= y + h);
        end
        if (hit) begin
          a.st = ST_COVERED;
        end else if (shadow_count >= MAX_ENTRIES) begin
          a.st = ST_FULL;
        end else begin
          shadow_rects[shadow_count] = q.r;
          shadow_count++;
          if (shadow_count > rects_written) begin
            rects_written = shadow_count;
          end
          a.st = ST_ADDED;
        end
      end
      FN_CLEAR: begin
        shadow_count = 0;
        a.st = ST_CLEARED;
      end
      FN_READ: begin
        a.st = ST_READ;
        a.r = shadow_rects[q.idx];
      end
      default: begin
        return 1'b0;
      end
    endcase
    a.cnt = shadow_count[ECNT_W-1:0];
    return 1'b1;
  endfunction

  function automatic int pick_edge();
    case ($urandom_range(0, 4))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_size();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 65535;
      2: return 1;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // Kinds: 0 small clustered rectangle, 1 piece of a stored rectangle, 2 anything,
  // 3 field extremes.
  function automatic req_t gen_add(input int kind);
    req_t q;
    rect_t s;
    q.func = FN_ADD;
    q.idx = IDX_W'($urandom);
    if (kind == 1 && shadow_count == 0) begin
      kind = 2;
    end
    case (kind)
      0: q.r = mk_rect($urandom_range(0, 40) - 20, $urandom_range(0, 40) - 20,
                       $urandom_range(0, 24), $urandom_range(0, 24));
      1: begin
        s = shadow_rects[$urandom_range(0, shadow_count - 1)];
        q.r = s;
        q.r.w = 16'($urandom_range(0, s.w));
        q.r.h = 16'($urandom_range(0, s.h));
      end
      2: q.r = rect_t'({$urandom, $urandom});
      default: q.r = mk_rect(pick_edge(), pick_edge(), pick_size(), pick_size());
    endcase
    return q;
  endfunction

  function automatic req_t gen_random_req();
    req_t q;
    int r;
    int k;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 9);
    q.r = rect_t'({$urandom, $urandom});
    q.idx = IDX_W'($urandom);
    if (r < 5) begin
      q.func = FN_NONE;
    end else if (r < 10) begin
      q.func = FN_CLEAR;
    end else if (r < 35 && rects_written > 0) begin
      q.func = FN_READ;
      q.idx = IDX_W'($urandom_range(0, rects_written - 1));
    end else begin
      q = gen_add((k < 4) ? 0 : (k < 6) ? 1 : (k < 8) ? 2 : 3);
    end
    return q;
  endfunction

  task automatic send_req(input req_t q, input bit typed, input reply_t typed_reply);
    reply_t a;
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser = q.func;
    s_tdata = {{(IN_DATA_W - IDX_W - 64){1'b0}}, q.idx, q.r};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (apply_request(q, a)) begin
      tracker_replies_q.push_back(typed ? typed_reply : a);
      sent++;
    end
  endtask

  task automatic pause_src(input int n);
    @(negedge clk);
    s_tvalid = 1'b0;
    s_tuser = IN_USER_W'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic maybe_pause();
    if (!calm && (sent % 128) >= 32 && $urandom_range(0, 5) == 0) begin
      pause_src($urandom_range(1, 14));
    end
  endtask

  task automatic note_bad(input string msg);
    bad_count++;
    if (bad_count <= MAX_REPORTS) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  initial begin
    row_t d;
    req_t q;
    reply_t t;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = '0;
    s_tdata = '0;
    t = '0;
    shadow_count = 0;
    rects_written = 0;
    sent = 0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      d = dir_rows[i];
      q.func = d.func;
      q.r = mk_rect(d.x, d.y, d.w, d.h);
      q.idx = d.idx[IDX_W-1:0];
      t.st = d.st;
      t.cnt = d.cnt[ECNT_W-1:0];
      t.r = mk_rect(d.ox, d.oy, d.ow, d.oh);
      send_req(q, d.typed, t);
      maybe_pause();
    end

    // Fill the list with rectangles that never contain each other: each one lies further
    // right and higher up than all before it.
    q.func = FN_CLEAR;
    send_req(q, 1'b0, t);
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      q.func = FN_ADD;
      q.r = mk_rect(-32768 + i * 128 + $urandom_range(0, 127),
                    32767 - i * 128 - $urandom_range(0, 127),
                    $urandom_range(0, 65535), $urandom_range(0, 65535));
      send_req(q, 1'b0, t);
      maybe_pause();
    end

    hold_req = 1'b1;
    for (int j = 0; j < 40; j++) begin
      if (j % 4 == 2) begin
        q.func = FN_READ;
        q.idx = (j == 2) ? '0 : (j == 6) ? IDX_W'(MAX_ENTRIES - 1) :
                IDX_W'($urandom_range(0, MAX_ENTRIES - 1));
      end else begin
        q = gen_add((j % 4 == 0) ? 2 : j % 4);
      end
      send_req(q, 1'b0, t);
      maybe_pause();
    end
    q.func = FN_CLEAR;
    send_req(q, 1'b0, t);

    while (sent < NUM_ITEMS) begin
      calm = (sent >= NUM_ITEMS - CALM_ITEMS);
      send_req(gen_random_req(), 1'b0, t);
      maybe_pause();
    end

    @(negedge clk);
    s_tvalid = 1'b0;
    while (tracker_replies_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (bad_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    m_tready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        m_tready = 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(negedge clk);
        hold_done = 1'b1;
        m_tready = 1'b1;
      end else if (!calm && (replies_seen % 100) >= 25 && $urandom_range(0, 7) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk);
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      replies_seen++;
      got.st = status_t'(m_tdata[2:0]);
      got.cnt = m_tdata[12:3];
      got.r.x = m_tdata[28:13];
      got.r.y = m_tdata[44:29];
      got.r.w = m_tdata[60:45];
      got.r.h = m_tdata[76:61];
      if (tracker_replies_q.size() == 0) begin
        note_bad($sformatf("result with no request pending: status %0d count %0d",
                           got.st, got.cnt));
      end else begin
        want = tracker_replies_q.pop_front();
        if (got.st !== want.st || got.cnt !== want.cnt || got.r.x !== want.r.x ||
            got.r.y !== want.r.y || got.r.w !== want.r.w || got.r.h !== want.r.h) begin
          note_bad($sformatf({"mismatch exp/got: status %0d/%0d count %0d/%0d ",
                              "x %0d/%0d y %0d/%0d w %0d/%0d h %0d/%0d"},
                             want.st, got.st, want.cnt, got.cnt, want.r.x, got.r.x,
                             want.r.y, got.r.y, want.r.w, got.r.w, want.r.h, got.r.h));
        end
      end
    end
  end

  initial begin
    #6000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
